// ===== hw/rtl/cmdc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmdc_pkg
// shared constants and types for the multisynth divider calculator
// ----------------------------------------------------------------------------
package cmdc_pkg;

   localparam int TGT_BITS  = 20;
   localparam int BYTE_BITS = 8;
   localparam int FRAC_BITS = 20;
   localparam int T_BITS    = 7;
   localparam int P1_BITS   = 18;

   localparam logic [FRAC_BITS-1:0] DENOM      = 20'd1048575;
   localparam logic [P1_BITS-1:0]   P1_OFFSET  = 18'd512;
   localparam logic [FRAC_BITS-1:0] P3_EXACT4  = 20'd1;
   localparam logic [1:0]           DIVBY4_ON  = 2'h3;
   localparam logic [1:0]           DIVBY4_OFF = 2'h0;

   localparam logic [TGT_BITS-1:0]  RST_PLL = 20'd800000;
   localparam logic [TGT_BITS-1:0]  RST_MIN = 20'd1000;
   localparam logic [TGT_BITS-1:0]  RST_MAX = 20'd150000;

   typedef enum logic [1:0] {
      CSR_PLL = 2'd0,
      CSR_MIN = 2'd1,
      CSR_MAX = 2'd2
   } csr_index_type;

endpackage

// ===== hw/rtl/clock_multisynth_divider_calc.sv =====
// ----------------------------------------------------------------------------
// clock_multisynth_divider_calc
// pipelined calculator of multisynth P1/P2/P3 register bytes from a target
// ----------------------------------------------------------------------------
// usage:
//   - write pll_khz (index 0), min_khz (1), max_khz (2) on the csr_ port
//     while no item is in flight
//   - an item is taken at a clock edge with start high and busy low; busy is
//     high only while reset is asserted, so one target per cycle is taken
//   - each item gives exactly one result, shown for one cycle with rsp_valid
//   - the pipeline is one input register, FREQ_BITS
//     restoring steps for pll / target, one stage forming rem * 1048575,
//     20 restoring steps for the fraction b, one stage for t and P2 (division
//     by 2^20-1 done as fold and correct), and one output register
//   - throughput is one item per cycle; each restoring step does one
//     subtract-and-compare
//   - a refused target (zero, below min or above max) gives status 1, zero
//     bytes and the unchanged held frequency
//   - the held frequency is updated when the item enters, so items in flight
//     carry the value in effect after them
//   - reset clears the valid bits, the held frequency and restores the
//     config defaults; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module clock_multisynth_divider_calc
   import cmdc_pkg::*;
#(
   parameter int FREQ_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [TGT_BITS-1:0]    req_target_khz,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [FREQ_BITS-1:0]   csr_wdata,
   output logic                   rsp_valid,
   output logic                   rsp_status,
   output logic [BYTE_BITS-1:0]   rsp_byte0,
   output logic [BYTE_BITS-1:0]   rsp_byte1,
   output logic [BYTE_BITS-1:0]   rsp_byte2,
   output logic [BYTE_BITS-1:0]   rsp_byte3,
   output logic [BYTE_BITS-1:0]   rsp_byte4,
   output logic [BYTE_BITS-1:0]   rsp_byte5,
   output logic [BYTE_BITS-1:0]   rsp_byte6,
   output logic [BYTE_BITS-1:0]   rsp_byte7,
   output logic [TGT_BITS-1:0]    rsp_held_khz
);

   // compare width wide enough for target and config registers
   localparam int CW = (FREQ_BITS > TGT_BITS) ? FREQ_BITS : TGT_BITS;
   localparam int NA = 11;   // quotient bits that reach P1 after the mod 2^18

   // config registers
   logic [FREQ_BITS-1:0] pll_ff, min_ff, max_ff;
   logic [TGT_BITS-1:0]  cur_ff, cur_in;
   logic                 in_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pll_ff <= FREQ_BITS'(RST_PLL);
         min_ff <= FREQ_BITS'(RST_MIN);
         max_ff <= FREQ_BITS'(RST_MAX);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PLL: pll_ff <= csr_wdata;
            CSR_MIN: min_ff <= csr_wdata;
            CSR_MAX: max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = reset;

   logic take;
   assign take = start & ~busy;

   // range check at entry, the held frequency follows the item order
   assign in_ok = (req_target_khz != '0) &&
                  (CW'(req_target_khz) >= CW'(min_ff)) &&
                  (CW'(req_target_khz) <= CW'(max_ff));
   assign cur_in = (take && in_ok) ? req_target_khz : cur_ff;

   always_ff @(posedge clock) begin
      if (reset) cur_ff <= '0;
      else       cur_ff <= cur_in;
   end

   // --------------------------------------------------------------------
   // first divider: pll / target, one quotient bit per stage
   // --------------------------------------------------------------------
   logic                 d1_v_ff    [0:FREQ_BITS];
   logic                 d1_ok_ff   [0:FREQ_BITS];
   logic [TGT_BITS-1:0]  d1_f_ff    [0:FREQ_BITS];
   logic [TGT_BITS-1:0]  d1_held_ff [0:FREQ_BITS];
   logic [TGT_BITS-1:0]  d1_r_ff    [0:FREQ_BITS];
   logic [FREQ_BITS-1:0] d1_n_ff    [0:FREQ_BITS];
   logic [TGT_BITS-1:0]  d1_r_in    [0:FREQ_BITS-1];
   logic [FREQ_BITS-1:0] d1_n_in    [0:FREQ_BITS-1];

   genvar j;
   generate
      for (j = 0; j < FREQ_BITS; j++) begin : g_d1
         logic [TGT_BITS:0] rr;
         logic [TGT_BITS:0] diff;
         logic              ge;
         assign rr   = {d1_r_ff[j], d1_n_ff[j][FREQ_BITS-1]};
         assign diff = rr - {1'b0, d1_f_ff[j]};
         assign ge   = (rr >= {1'b0, d1_f_ff[j]});
         assign d1_r_in[j] = ge ? diff[TGT_BITS-1:0] : rr[TGT_BITS-1:0];
         assign d1_n_in[j] = {d1_n_ff[j][FREQ_BITS-2:0], ge};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= FREQ_BITS; k++) d1_v_ff[k] <= 1'b0;
      end else begin
         d1_v_ff[0] <= take;
         for (int k = 0; k < FREQ_BITS; k++) d1_v_ff[k+1] <= d1_v_ff[k];
      end
      d1_ok_ff[0]   <= in_ok;
      d1_f_ff[0]    <= req_target_khz;
      d1_held_ff[0] <= cur_in;
      d1_r_ff[0]    <= '0;
      d1_n_ff[0]    <= pll_ff;
      for (int k = 0; k < FREQ_BITS; k++) begin
         d1_ok_ff[k+1]   <= d1_ok_ff[k];
         d1_f_ff[k+1]    <= d1_f_ff[k];
         d1_held_ff[k+1] <= d1_held_ff[k];
         d1_r_ff[k+1]    <= d1_r_in[k];
         d1_n_ff[k+1]    <= d1_n_in[k];
      end
   end

   // --------------------------------------------------------------------
   // numerator rem * (2^20 - 1), exact-divide-by-4 detection
   // --------------------------------------------------------------------
   logic [2*FRAC_BITS-1:0] num;
   logic                   spec_in;
   assign num = {d1_r_ff[FREQ_BITS], {FRAC_BITS{1'b0}}} -
                {{FRAC_BITS{1'b0}}, d1_r_ff[FREQ_BITS]};
   assign spec_in = (d1_n_ff[FREQ_BITS] == FREQ_BITS'(4)) &&
                    (d1_r_ff[FREQ_BITS] == '0);

   // --------------------------------------------------------------------
   // second divider: b = num / target, 20 fraction bits
   // --------------------------------------------------------------------
   logic                 d2_v_ff    [0:FRAC_BITS];
   logic                 d2_ok_ff   [0:FRAC_BITS];
   logic                 d2_spec_ff [0:FRAC_BITS];
   logic [NA-1:0]        d2_a_ff    [0:FRAC_BITS];
   logic [TGT_BITS-1:0]  d2_f_ff    [0:FRAC_BITS];
   logic [TGT_BITS-1:0]  d2_held_ff [0:FRAC_BITS];
   logic [TGT_BITS-1:0]  d2_r_ff    [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] d2_n_ff    [0:FRAC_BITS];
   logic [TGT_BITS-1:0]  d2_r_in    [0:FRAC_BITS-1];
   logic [FRAC_BITS-1:0] d2_n_in    [0:FRAC_BITS-1];

   generate
      for (j = 0; j < FRAC_BITS; j++) begin : g_d2
         logic [TGT_BITS:0] rr;
         logic [TGT_BITS:0] diff;
         logic              ge;
         assign rr   = {d2_r_ff[j], d2_n_ff[j][FRAC_BITS-1]};
         assign diff = rr - {1'b0, d2_f_ff[j]};
         assign ge   = (rr >= {1'b0, d2_f_ff[j]});
         assign d2_r_in[j] = ge ? diff[TGT_BITS-1:0] : rr[TGT_BITS-1:0];
         assign d2_n_in[j] = {d2_n_ff[j][FRAC_BITS-2:0], ge};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= FRAC_BITS; k++) d2_v_ff[k] <= 1'b0;
      end else begin
         d2_v_ff[0] <= d1_v_ff[FREQ_BITS];
         for (int k = 0; k < FRAC_BITS; k++) d2_v_ff[k+1] <= d2_v_ff[k];
      end
      d2_ok_ff[0]   <= d1_ok_ff[FREQ_BITS];
      d2_spec_ff[0] <= spec_in;
      d2_a_ff[0]    <= d1_n_ff[FREQ_BITS][NA-1:0];
      d2_f_ff[0]    <= d1_f_ff[FREQ_BITS];
      d2_held_ff[0] <= d1_held_ff[FREQ_BITS];
      d2_r_ff[0]    <= num[2*FRAC_BITS-1:FRAC_BITS];
      d2_n_ff[0]    <= num[FRAC_BITS-1:0];
      for (int k = 0; k < FRAC_BITS; k++) begin
         d2_ok_ff[k+1]   <= d2_ok_ff[k];
         d2_spec_ff[k+1] <= d2_spec_ff[k];
         d2_a_ff[k+1]    <= d2_a_ff[k];
         d2_f_ff[k+1]    <= d2_f_ff[k];
         d2_held_ff[k+1] <= d2_held_ff[k];
         d2_r_ff[k+1]    <= d2_r_in[k];
         d2_n_ff[k+1]    <= d2_n_in[k];
      end
   end

   // --------------------------------------------------------------------
   // t = 128b / (2^20-1) and P2 as its remainder: fold the high bits back in
   // --------------------------------------------------------------------
   logic [FRAC_BITS+T_BITS-1:0] x128;
   logic [T_BITS-1:0]           tq;
   logic [FRAC_BITS:0]          fold;
   logic                        fold_ge;
   logic [T_BITS-1:0]           t_in;
   logic [FRAC_BITS-1:0]        p2_in;
   logic [FRAC_BITS:0]          fold_sub;

   assign x128     = {d2_n_ff[FRAC_BITS], {T_BITS{1'b0}}};
   assign tq       = x128[FRAC_BITS+T_BITS-1:FRAC_BITS];
   assign fold     = {1'b0, x128[FRAC_BITS-1:0]} + {{(FRAC_BITS+1-T_BITS){1'b0}}, tq};
   assign fold_ge  = (fold >= {1'b0, DENOM});
   assign fold_sub = fold - {1'b0, DENOM};
   assign t_in     = fold_ge ? (tq + T_BITS'(1)) : tq;
   assign p2_in    = fold_ge ? fold_sub[FRAC_BITS-1:0] : fold[FRAC_BITS-1:0];

   logic                 t_v_ff, t_ok_ff, t_spec_ff;
   logic [NA-1:0]        t_a_ff;
   logic [T_BITS-1:0]    t_t_ff;
   logic [FRAC_BITS-1:0] t_p2_ff;
   logic [TGT_BITS-1:0]  t_held_ff;

   always_ff @(posedge clock) begin
      if (reset) t_v_ff <= 1'b0;
      else       t_v_ff <= d2_v_ff[FRAC_BITS];
      t_ok_ff   <= d2_ok_ff[FRAC_BITS];
      t_spec_ff <= d2_spec_ff[FRAC_BITS];
      t_a_ff    <= d2_a_ff[FRAC_BITS];
      t_held_ff <= d2_held_ff[FRAC_BITS];
      t_t_ff    <= t_in;
      t_p2_ff   <= p2_in;
   end

   // --------------------------------------------------------------------
   // P1, special case, byte packing, output register
   // --------------------------------------------------------------------
   logic [P1_BITS-1:0]   p1_raw, p1;
   logic [FRAC_BITS-1:0] p2, p3;
   logic [1:0]           d4;

   assign p1_raw = {t_a_ff, {T_BITS{1'b0}}} + {{(P1_BITS-T_BITS){1'b0}}, t_t_ff}
                   - P1_OFFSET;

   always_comb begin
      if (t_spec_ff) begin
         p1 = '0;
         p2 = '0;
         p3 = P3_EXACT4;
         d4 = DIVBY4_ON;
      end else begin
         p1 = p1_raw;
         p2 = t_p2_ff;
         p3 = DENOM;
         d4 = DIVBY4_OFF;
      end
   end

   logic                 o_v_ff, o_st_ff;
   logic [BYTE_BITS-1:0] o_b_ff [0:7];
   logic [TGT_BITS-1:0]  o_held_ff;

   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else       o_v_ff <= t_v_ff;
      o_st_ff   <= ~t_ok_ff;
      o_held_ff <= t_held_ff;
      if (t_ok_ff) begin
         o_b_ff[0] <= p3[15:8];
         o_b_ff[1] <= p3[7:0];
         o_b_ff[2] <= {4'h0, d4, p1[17:16]};
         o_b_ff[3] <= p1[15:8];
         o_b_ff[4] <= p1[7:0];
         o_b_ff[5] <= {p3[19:16], p2[19:16]};
         o_b_ff[6] <= p2[15:8];
         o_b_ff[7] <= p2[7:0];
      end else begin
         for (int k = 0; k < 8; k++) o_b_ff[k] <= '0;
      end
   end

   assign rsp_valid    = o_v_ff;
   assign rsp_status   = o_st_ff;
   assign rsp_byte0    = o_b_ff[0];
   assign rsp_byte1    = o_b_ff[1];
   assign rsp_byte2    = o_b_ff[2];
   assign rsp_byte3    = o_b_ff[3];
   assign rsp_byte4    = o_b_ff[4];
   assign rsp_byte5    = o_b_ff[5];
   assign rsp_byte6    = o_b_ff[6];
   assign rsp_byte7    = o_b_ff[7];
   assign rsp_held_khz = o_held_ff;

endmodule

// ===== test/clock_multisynth_divider_calc_tb.sv =====
// ----------------------------------------------------------------------------
// clock_multisynth_divider_calc_tb
// drives target frequencies through several divider settings and checks
// every multisynth byte, status and held frequency against a local predictor
// ----------------------------------------------------------------------------
module clock_multisynth_divider_calc_tb;
   import cmdc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int           FREQ_BITS   = 20;
   localparam logic [1:0]   CSR_UNUSED  = 2'd3;
   localparam logic [19:0]  FMAX        = 20'hFFFFF;
   localparam int           CYCLE_LIMIT = 400000;
   localparam int           DRAIN_WAIT  = FREQ_BITS + 40;

   typedef struct packed {
      logic                 status;
      logic [7:0]           byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;
      logic [TGT_BITS-1:0]  held_khz;
   } divider_result_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [TGT_BITS-1:0]    req_target_khz;
   logic                   csr_we;
   logic [1:0]             csr_index;
   logic [FREQ_BITS-1:0]   csr_wdata;
   logic                   rsp_valid;
   logic                   rsp_status;
   logic [7:0]             rsp_byte0, rsp_byte1, rsp_byte2, rsp_byte3;
   logic [7:0]             rsp_byte4, rsp_byte5, rsp_byte6, rsp_byte7;
   logic [TGT_BITS-1:0]    rsp_held_khz;

   // predictor copy of the divider settings and the held frequency
   logic [63:0]            model_pll, model_min, model_max, model_held;

   logic [TGT_BITS-1:0]    pending_targets[$];
   divider_result_type     expected_results[$];
   int                     idle_pct;
   int                     cycle_count;
   int                     error_count;
   logic                   took_item;

   clock_multisynth_divider_calc #(.FREQ_BITS(FREQ_BITS)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_target_khz(req_target_khz),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_byte0(rsp_byte0), .rsp_byte1(rsp_byte1), .rsp_byte2(rsp_byte2),
      .rsp_byte3(rsp_byte3), .rsp_byte4(rsp_byte4), .rsp_byte5(rsp_byte5),
      .rsp_byte6(rsp_byte6), .rsp_byte7(rsp_byte7),
      .rsp_held_khz(rsp_held_khz)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // works out the register bytes for one target and advances the held frequency
   function automatic divider_result_type compute_divider_bytes(logic [TGT_BITS-1:0] target);
      divider_result_type r;
      logic [63:0] f, a, rem, b, t, p1, p2, p3, d4;
      r = '0;
      f = 64'(target);
      // zero is refused regardless of the range so nothing divides by zero
      if (f == 0 || f < model_min || f > model_max) begin
         r.status   = 1'b1;
         r.held_khz = model_held[19:0];
         return r;
      end
      a   = model_pll / f;
      rem = model_pll % f;
      if (a == 4 && rem == 0) begin
         // exact divide by four uses the dedicated encoding
         p1 = 0;
         p2 = 0;
         p3 = 64'(P3_EXACT4);
         d4 = 64'(DIVBY4_ON);
      end else begin
         b  = (rem * 64'(DENOM)) / f;
         t  = (64'd128 * b) / 64'(DENOM);
         // small quotients wrap; only 18 bits of p1 are kept
         p1 = (64'd128 * a + t - 64'(P1_OFFSET)) & 64'h3FFFF;
         p2 = (64'd128 * b - t * 64'(DENOM)) & 64'hFFFFF;
         p3 = 64'(DENOM);
         d4 = 64'(DIVBY4_OFF);
      end
      r.byte0 = p3[15:8];
      r.byte1 = p3[7:0];
      r.byte2 = {4'h0, d4[1:0], p1[17:16]};
      r.byte3 = p1[15:8];
      r.byte4 = p1[7:0];
      r.byte5 = {p3[19:16], p2[19:16]};
      r.byte6 = p2[15:8];
      r.byte7 = p2[7:0];
      model_held = f;
      r.held_khz = f[19:0];
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   // register write, mirrored into the predictor at the write edge
   task automatic write_csr(logic [1:0] idx, logic [FREQ_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PLL: model_pll = 64'(value);
         CSR_MIN: model_min = 64'(value);
         CSR_MAX: model_max = 64'(value);
         default: ;
      endcase
   endtask

   task automatic set_range(logic [19:0] pll, logic [19:0] lo, logic [19:0] hi);
      write_csr(CSR_PLL, pll);
      write_csr(CSR_MIN, lo);
      write_csr(CSR_MAX, hi);
   endtask

   // mostly in-range targets, some raw noise, edges and the quarter of pll plus or minus one
   task automatic queue_random_targets(int count);
      logic [19:0] tgt;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         if (pick < 7 && model_min <= model_max)
            tgt = 20'($urandom_range(model_max[19:0], model_min[19:0]));
         else if (pick < 8)
            tgt = 20'($urandom);
         else if (pick < 9)
            case ($urandom_range(6))
               0: tgt = 20'd0;
               1: tgt = model_min[19:0];
               2: tgt = model_max[19:0];
               3: tgt = model_min[19:0] - 20'd1;
               4: tgt = model_max[19:0] + 20'd1;
               5: tgt = 20'd1;
               default: tgt = FMAX;
            endcase
         else
            tgt = model_pll[21:2] + 20'($urandom_range(2)) - 20'd1;
         pending_targets.push_back(tgt);
      end
   endtask

   // wait until every item is taken and its result checked
   task automatic drain;
      while (pending_targets.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // driver: holds an item until taken, then picks the next or idles
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         took_item = start && !busy;
         if (took_item) begin
            expected_results.push_back(compute_divider_bytes(req_target_khz));
            void'(pending_targets.pop_front());
         end
         if (start && !took_item) begin
            start <= 1'b1;
         end else if (pending_targets.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start          <= 1'b1;
            req_target_khz <= pending_targets[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed result against the oldest expectation
   always @(posedge clock) begin
      divider_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding");
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            check_field("status", 64'(exp_r.status), 64'(rsp_status));
            check_field("byte0", 64'(exp_r.byte0), 64'(rsp_byte0));
            check_field("byte1", 64'(exp_r.byte1), 64'(rsp_byte1));
            check_field("byte2", 64'(exp_r.byte2), 64'(rsp_byte2));
            check_field("byte3", 64'(exp_r.byte3), 64'(rsp_byte3));
            check_field("byte4", 64'(exp_r.byte4), 64'(rsp_byte4));
            check_field("byte5", 64'(exp_r.byte5), 64'(rsp_byte5));
            check_field("byte6", 64'(exp_r.byte6), 64'(rsp_byte6));
            check_field("byte7", 64'(exp_r.byte7), 64'(rsp_byte7));
            check_field("held_khz", 64'(exp_r.held_khz), 64'(rsp_held_khz));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("clock_multisynth_divider_calc_tb failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_target_khz = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_PLL;
      csr_wdata      = '0;
      cycle_count    = 0;
      error_count    = 0;
      idle_pct       = 8;
      model_pll      = 64'(RST_PLL);
      model_min      = 64'(RST_MIN);
      model_max      = 64'(RST_MAX);
      model_held     = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: refusals on both sides of the range and its edges
      pending_targets = '{20'd0, 20'd999, 20'd1000, 20'd150000, 20'd150001,
                          FMAX, 20'd114286, 20'd1234};
      queue_random_targets(120);
      drain();

      // full range: exact divide by four, small quotients, zero with min of zero
      set_range(20'd800000, 20'd0, FMAX);
      pending_targets = '{20'd200000, 20'd0, 20'd800000, 20'd400000, 20'd266667,
                          FMAX, 20'd1, 20'd3, 20'd199999, 20'd200001};
      queue_random_targets(210);
      drain();

      // largest pll
      set_range(FMAX, 20'd1, FMAX);
      pending_targets = '{20'd1, 20'd2, FMAX, 20'h55555, 20'hAAAAA};
      queue_random_targets(220);
      drain();

      idle_pct = 80;
      // tiny pll, every quotient below four
      set_range(20'd1, 20'd1, 20'd1000);
      queue_random_targets(200);
      drain();

      // pll of zero, plus a write to an unused index that must be ignored
      set_range(20'd0, 20'd1, 20'd5000);
      write_csr(CSR_UNUSED, 20'd7);
      queue_random_targets(200);
      drain();

      // empty range refuses everything
      set_range(20'd800000, 20'd5000, 20'd4000);
      pending_targets = '{20'd4000, 20'd4500, 20'd5000};
      queue_random_targets(200);
      drain();

      idle_pct = 0;
      set_range(20'($urandom_range(20'hFFFFF, 1)), 20'($urandom_range(5000, 1)),
                20'($urandom_range(20'hFFFFF, 200000)));
      queue_random_targets(300);
      drain();

      set_range(RST_PLL, RST_MIN, RST_MAX);
      queue_random_targets(300);
      drain();

      if (error_count == 0) begin
         $display("clock_multisynth_divider_calc_tb passed");
      end else begin
         $display("clock_multisynth_divider_calc_tb failed");
      end
      $finish;
   end

endmodule
